[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assertion macros
// shorthand for clocked concurrent assertions used by the checker
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every rising edge while reset is released
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// property checked on every rising edge, reset included
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/dct2_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct2_pkg
// shared types, constants and the cosine table function of the dct-ii block
// ----------------------------------------------------------------------------
package dct2_pkg;

  localparam int SAMPLE_COUNT_DEF = 32;

  localparam int SAMPLE_W = 16;
  localparam int COEF_W   = 23;
  localparam int INDEX_W  = 5;
  localparam int QCOS_W   = 15;   // quarter-wave magnitude, 0..32767
  localparam int COS_W    = 16;   // signed cosine, q1.15
  localparam int PROD_W   = 32;

  localparam int QUEUE_DEPTH = 2; // one slot per sample bank, power of two

  localparam longint Q30_ONE     = 64'sd1073741824;
  localparam longint HALF_PI_Q30 = 64'sd1686629713;
  localparam longint TAYLOR_DIV [0:6] = '{182, 132, 90, 56, 30, 12, 2};

  localparam int     ROUND_BIAS  = 8192;
  localparam int     ROUND_SHIFT = 14;
  localparam longint COEF_MAX    = 64'sd4194303;
  localparam longint COEF_MIN    = -64'sd4194304;

  // bank token: a full sample bank handed to the back end, or released by it
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_tok_t;

  typedef enum logic [1:0] {
    QUAD_0,
    QUAD_1,
    QUAD_2,
    QUAD_3
  } quad_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_RUN,
    BK_FLUSH,
    BK_EMIT
  } bk_state_t;

  // quarter-wave cosine from phase t = pi/2 * r/n in q2.30, evaluated at elaboration
  function automatic logic [QCOS_W-1:0] qcos_from_t(input longint t);
    longint t2;
    longint h;
    int     i;
    t2 = (t * t) / Q30_ONE;
    h  = Q30_ONE;
    for (i = 0; i < 7; i++) begin
      h = Q30_ONE - ((t2 * h) / Q30_ONE) / TAYLOR_DIV[i];
    end
    if (h < 0) begin
      h = 0;
    end
    if (h > Q30_ONE) begin
      h = Q30_ONE;
    end
    h = (h + 64'sd16384) / 64'sd32768;
    if (h > 64'sd32767) begin
      h = 64'sd32767;
    end
    return h[QCOS_W-1:0];
  endfunction

endpackage

[sv/dct2_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct2_front
// takes samples into one of two banks and hands a full bank to the queue
// ----------------------------------------------------------------------------
module dct2_front import dct2_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  input  bank_tok_t                  release_tok,
  output bank_tok_t                  push_tok,
  output logic                       wr_en,
  output logic [$clog2(SAMPLE_COUNT):0] wr_addr,
  output logic signed [SAMPLE_W-1:0] wr_data
);

  localparam int K_W = $clog2(SAMPLE_COUNT);
  localparam logic [K_W-1:0] LAST_POS = K_W'(SAMPLE_COUNT - 1);

  logic [K_W-1:0] load_cnt_r, load_cnt_nxt;
  logic           bank_r, bank_nxt;
  logic [1:0]     busy_r, busy_nxt;
  logic           accept;
  logic           block_end;

  // a bank still owned by the queue or the back end cannot be refilled
  assign in_stall  = busy_r[bank_r];
  assign accept    = in_valid && !in_stall;
  assign block_end = accept && (load_cnt_r == LAST_POS);

  assign wr_en   = accept;
  assign wr_addr = {bank_r, load_cnt_r};
  assign wr_data = in_sample;

  assign push_tok.valid = block_end;
  assign push_tok.bank  = bank_r;

  always_comb begin
    load_cnt_nxt = load_cnt_r;
    bank_nxt     = bank_r;
    busy_nxt     = busy_r;
    if (accept) begin
      load_cnt_nxt = block_end ? '0 : load_cnt_r + 1'b1;
    end
    if (block_end) begin
      bank_nxt = !bank_r;
    end
    if (release_tok.valid) begin
      busy_nxt[release_tok.bank] = 1'b0;
    end
    if (push_tok.valid) begin
      busy_nxt[push_tok.bank] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      load_cnt_r <= '0;
      bank_r     <= 1'b0;
      busy_r     <= '0;
    end else begin
      load_cnt_r <= load_cnt_nxt;
      bank_r     <= bank_nxt;
      busy_r     <= busy_nxt;
    end
  end

endmodule

[sv/dct2_queue.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct2_queue
// small fifo of full-bank tokens between the front and back ends
// ----------------------------------------------------------------------------
module dct2_queue import dct2_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  bank_tok_t push_tok,
  input  logic      pop,
  output bank_tok_t head_tok
);

  localparam int QP_W = $clog2(QUEUE_DEPTH);

  logic            slot_r [0:QUEUE_DEPTH-1];
  logic [QP_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [QP_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [QP_W:0]   cnt_r, cnt_nxt;

  assign head_tok.valid = (cnt_r != '0);
  assign head_tok.bank  = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push_tok.valid ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r + (QP_W+1)'(push_tok.valid) - (QP_W+1)'(pop);
  end

  always_ff @(posedge clk) begin
    if (push_tok.valid) begin
      slot_r[wr_ptr_r] <= push_tok.bank;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

[sv/dct2_back.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct2_back
// sample memory, cosine lookup and a single multiply-accumulate unit shared by all coefficients
// ----------------------------------------------------------------------------
module dct2_back import dct2_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [$clog2(SAMPLE_COUNT):0] wr_addr,
  input  logic signed [SAMPLE_W-1:0]    wr_data,
  input  bank_tok_t                     head_tok,
  output logic                          pop,
  output bank_tok_t                     release_tok,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [COEF_W-1:0]      out_coefficient,
  output logic [INDEX_W-1:0]            out_coef_index,
  output logic                          out_last
);

  localparam int K_W       = $clog2(SAMPLE_COUNT);
  localparam int ADDR_W    = K_W + 1;
  localparam int MEM_DEPTH = 2 ** ADDR_W;
  localparam int PH_W      = K_W + 2;
  localparam int R_W       = $clog2(SAMPLE_COUNT + 1);
  localparam int ACC_W     = PROD_W + K_W;
  localparam int RND_W     = (ACC_W + 1 > 38) ? ACC_W + 1 : 38;

  localparam logic [K_W-1:0]  LAST_K  = K_W'(SAMPLE_COUNT - 1);
  localparam logic [PH_W-1:0] N1      = PH_W'(SAMPLE_COUNT);
  localparam logic [PH_W-1:0] N2      = PH_W'(2 * SAMPLE_COUNT);
  localparam logic [PH_W-1:0] N3      = PH_W'(3 * SAMPLE_COUNT);
  localparam logic [PH_W:0]   PERIOD  = (PH_W+1)'(4 * SAMPLE_COUNT);
  localparam logic [R_W-1:0]  N_R     = R_W'(SAMPLE_COUNT);

  // quarter-wave cosine table, one entry per phase step 0..n
  logic [QCOS_W-1:0] qcos_tbl [0:SAMPLE_COUNT];

  for (genvar r = 0; r <= SAMPLE_COUNT; r++) begin : g_qcos
    localparam longint TPH = (longint'(r) * HALF_PI_Q30) / SAMPLE_COUNT;
    assign qcos_tbl[r] = qcos_from_t(TPH);
  end

  logic signed [SAMPLE_W-1:0] mem_r [0:MEM_DEPTH-1];

  bk_state_t state_r, state_nxt;
  logic                       bank_r, bank_nxt;
  logic [K_W-1:0]             k_r, k_nxt;
  logic [K_W-1:0]             j_r, j_nxt;
  logic [PH_W-1:0]            phase_r, phase_nxt;
  logic                       v1_r, v1_nxt;
  logic                       v2_r, v2_nxt;
  logic signed [SAMPLE_W-1:0] rd_r;
  logic signed [COS_W-1:0]    cos_r;
  logic signed [PROD_W-1:0]   prod_r;
  logic signed [ACC_W-1:0]    acc_r, acc_nxt;
  logic                       out_valid_r, out_valid_nxt;
  logic signed [COEF_W-1:0]   coef_r;
  logic [INDEX_W-1:0]         index_r;
  logic                       last_r;

  logic                       out_free;
  logic                       last_coef;
  logic                       issue;
  logic                       emit;
  logic                       start;

  logic [PH_W:0]              psum;
  logic [PH_W-1:0]            phase_step;
  quad_t                      quad;
  logic [PH_W-1:0]            rem;
  logic [R_W-1:0]             rem_r;
  logic [R_W-1:0]             tbl_idx;
  logic [QCOS_W-1:0]          mag;
  logic signed [COS_W-1:0]    cos_val;

  logic signed [RND_W-1:0]    rnd;
  logic signed [RND_W-1:0]    shq;
  logic signed [COEF_W-1:0]   coef_sat;
  logic [K_W+INDEX_W-1:0]     k_ext;

  assign out_free  = !out_valid_r || !out_stall;
  assign last_coef = (k_r == LAST_K);

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      BK_IDLE: begin
        if (head_tok.valid) begin
          state_nxt = BK_RUN;
        end
      end
      BK_RUN: begin
        if (j_r == LAST_K) begin
          state_nxt = BK_FLUSH;
        end
      end
      BK_FLUSH: begin
        if (!v1_r && !v2_r) begin
          state_nxt = BK_EMIT;
        end
      end
      BK_EMIT: begin
        if (out_free) begin
          state_nxt = last_coef ? BK_IDLE : BK_RUN;
        end
      end
      default: state_nxt = BK_IDLE;
    endcase
  end

  // state outputs
  always_comb begin
    pop               = 1'b0;
    issue             = 1'b0;
    emit              = 1'b0;
    case (state_r)
      BK_IDLE:  pop   = head_tok.valid;
      BK_RUN:   issue = 1'b1;
      BK_FLUSH: issue = 1'b0;
      BK_EMIT:  emit  = out_free;
      default:  issue = 1'b0;
    endcase
    start             = pop || (emit && !last_coef);
    release_tok.valid = emit && last_coef;
    release_tok.bank  = bank_r;
  end

  // phase k*(2j+1) mod 4n advances by 2k per sample
  always_comb begin
    psum       = (PH_W+1)'(phase_r) + (PH_W+1)'({k_r, 1'b0});
    phase_step = (psum >= PERIOD) ? PH_W'(psum - PERIOD) : PH_W'(psum);
  end

  // quadrant fold onto the quarter-wave table
  always_comb begin
    if (phase_r < N1) begin
      quad = QUAD_0;
      rem  = phase_r;
    end else if (phase_r < N2) begin
      quad = QUAD_1;
      rem  = phase_r - N1;
    end else if (phase_r < N3) begin
      quad = QUAD_2;
      rem  = phase_r - N2;
    end else begin
      quad = QUAD_3;
      rem  = phase_r - N3;
    end
    rem_r   = R_W'(rem);
    tbl_idx = (quad == QUAD_1 || quad == QUAD_3) ? N_R - rem_r : rem_r;
    mag     = qcos_tbl[tbl_idx];
    cos_val = (quad == QUAD_1 || quad == QUAD_2) ? -$signed({1'b0, mag})
                                                 : $signed({1'b0, mag});
  end

  // round half up at 2^14, then clamp to the coefficient range
  always_comb begin
    rnd   = RND_W'(acc_r) + RND_W'(ROUND_BIAS);
    shq   = rnd >>> ROUND_SHIFT;
    k_ext = (K_W+INDEX_W)'(k_r);
    if (shq > RND_W'(COEF_MAX)) begin
      coef_sat = COEF_W'(COEF_MAX);
    end else if (shq < RND_W'(COEF_MIN)) begin
      coef_sat = COEF_W'(COEF_MIN);
    end else begin
      coef_sat = COEF_W'(shq);
    end
  end

  always_comb begin
    bank_nxt      = pop ? head_tok.bank : bank_r;
    k_nxt         = pop ? '0 : ((emit && !last_coef) ? k_r + 1'b1 : k_r);
    j_nxt         = start ? '0 : (issue ? j_r + 1'b1 : j_r);
    phase_nxt     = start ? PH_W'(k_nxt) : (issue ? phase_step : phase_r);
    v1_nxt        = issue;
    v2_nxt        = v1_r;
    acc_nxt       = start ? '0 : (v2_r ? acc_r + ACC_W'(prod_r) : acc_r);
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (issue) begin
      rd_r  <= mem_r[{bank_r, j_r}];
      cos_r <= cos_val;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= rd_r * cos_r;
    if (emit) begin
      coef_r  <= coef_sat;
      index_r <= k_ext[INDEX_W-1:0];
      last_r  <= last_coef;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= BK_IDLE;
      bank_r      <= 1'b0;
      k_r         <= '0;
      j_r         <= '0;
      phase_r     <= '0;
      v1_r        <= 1'b0;
      v2_r        <= 1'b0;
      acc_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      bank_r      <= bank_nxt;
      k_r         <= k_nxt;
      j_r         <= j_nxt;
      phase_r     <= phase_nxt;
      v1_r        <= v1_nxt;
      v2_r        <= v2_nxt;
      acc_r       <= acc_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_coefficient = coef_r;
  assign out_coef_index  = index_r;
  assign out_last        = last_r;

endmodule

[sv/dct_type2_block.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct_type2_block
// unnormalized dct-ii over blocks of SAMPLE_COUNT signed q1.15 samples
// ----------------------------------------------------------------------------
// One sample is taken per input transaction. After the SAMPLE_COUNT-th sample
// of a block the block delivers SAMPLE_COUNT result transactions, coefficient
// k = 0..N-1 in order, each 2 * sum x[j]*cos(pi*k*(2j+1)/(2N)) in q.15 units,
// rounded half up and clamped to 23 bits, with last set on k = N-1 and
// coef_index wrapping modulo 32. Samples go into one of two banks, so the next
// block loads while the previous one is transformed; input stalls only when
// both banks are full. Each coefficient is computed on the single
// multiply-accumulate unit: N sample reads, a drain through the read, product
// and accumulator registers, and a hand-off of the result to the output
// register, which waits while the output stalls. Each block first takes its
// bank from the queue.
// ----------------------------------------------------------------------------
module dct_type2_block import dct2_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF  // block length, 2..64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  // sample channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic signed [SAMPLE_W-1:0] in_sample,
  // coefficient channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic signed [COEF_W-1:0]   out_coefficient,
  output logic [INDEX_W-1:0]         out_coef_index,
  output logic                       out_last
);

  localparam int ADDR_W = $clog2(SAMPLE_COUNT) + 1;

  // sample memory write port, front to back
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic signed [SAMPLE_W-1:0] wr_data;

  // bank tokens: full bank pushed by the front, head seen by the back,
  // bank given back to the front once its last coefficient is out
  bank_tok_t push_tok;
  bank_tok_t head_tok;
  bank_tok_t release_tok;
  logic      pop;

  // front: counts samples within the block and picks the bank
  dct2_front #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_sample  (in_sample),
    .release_tok(release_tok),
    .push_tok   (push_tok),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data)
  );

  // queue of full banks waiting for the transform engine
  dct2_queue u_queue (
    .clk     (clk),
    .rst_n   (rst_n),
    .push_tok(push_tok),
    .pop     (pop),
    .head_tok(head_tok)
  );

  // back: memory, cosine lookup, mac and output register
  dct2_back #(
    .SAMPLE_COUNT(SAMPLE_COUNT)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .wr_en          (wr_en),
    .wr_addr        (wr_addr),
    .wr_data        (wr_data),
    .head_tok       (head_tok),
    .pop            (pop),
    .release_tok    (release_tok),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_coefficient(out_coefficient),
    .out_coef_index (out_coef_index),
    .out_last       (out_last)
  );

endmodule

[sv/dct2_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dct2_checker
// port-level checks on the coefficient channel of the dct-ii block
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module dct2_checker import dct2_pkg::*; #(
  parameter int SAMPLE_COUNT = SAMPLE_COUNT_DEF
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     out_valid,
  input logic                     out_stall,
  input logic signed [COEF_W-1:0] out_coefficient,
  input logic [INDEX_W-1:0]       out_coef_index,
  input logic                     out_last
);

  localparam logic [INDEX_W-1:0] LAST_IDX = INDEX_W'((SAMPLE_COUNT - 1) % (2 ** INDEX_W));

  // stalled transaction stays offered
  `ASSERT_CLK(a_out_valid_hold, clk, rst_n, out_valid && out_stall |=> out_valid, "out_valid dropped under stall")

  // stalled transaction keeps its payload
  `ASSERT_CLK(a_out_payload_hold, clk, rst_n, out_valid && out_stall |=> $stable(out_coefficient) && $stable(out_coef_index) && $stable(out_last), "payload changed under stall")

  // last flag only on the highest frequency index
  `ASSERT_CLK(a_last_index, clk, rst_n, out_valid && out_last |-> out_coef_index == LAST_IDX, "last flag on wrong index")

  // reset empties the output register
  `ASSERT_ALWAYS(a_reset_clears, clk, !rst_n |=> !out_valid, "out_valid set after reset")

endmodule

bind dct_type2_block dct2_checker #(
  .SAMPLE_COUNT(SAMPLE_COUNT)
) u_dct2_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .out_valid      (out_valid),
  .out_stall      (out_stall),
  .out_coefficient(out_coefficient),
  .out_coef_index (out_coef_index),
  .out_last       (out_last)
);
